>>> sv/gcb_pkg.sv
// Shared constants and the CORDIC arctangent table for the bearing pipeline.
`default_nettype none
package gcb_pkg;

    localparam int DEG_W   = 26;
    localparam int TURN_W  = 32;
    localparam int ROT_W   = 34;
    localparam int VEC_W   = 36;
    localparam int QUO_W   = 20;
    localparam int REM_W   = 6;
    localparam int FRAC_W  = 13;
    localparam int LAT_W   = 24;
    localparam int LON_W   = 25;
    localparam int BRG_W   = 9;

    // ceil(2^31 / 45): exact quotient by 45 for values below 2^26.
    localparam logic [25:0] RECIP_45 = 26'd47721859;
    localparam int          RECIP_SH = 31;

    localparam logic signed [ROT_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [TURN_W-1:0] QUARTER_TURN = 32'sd1073741824;

    localparam logic signed [LAT_W-1:0] DEST_LAT_RST = 24'sd1403947;
    localparam logic signed [LON_W-1:0] DEST_LON_RST = 25'sd2610049;

    localparam logic REG_DEST_LAT = 1'b0;
    localparam logic REG_DEST_LON = 1'b1;

    function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
        logic [TURN_W-1:0] t;
        unique case (idx)
            5'd0:  t = 32'h20000000;
            5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;
            5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;
            5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;
            5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;
            5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029;
            5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A;
            5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003;
            5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;
            5'd31: t = 32'h00000000;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

>>> sv/gcb_deg2turn.sv
// Five-stage conversion of degrees times 65536 into binary turns.
`default_nettype none
module gcb_deg2turn (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [gcb_pkg::DEG_W-1:0] in_deg,
    output logic                               out_valid,
    output logic [gcb_pkg::TURN_W-1:0]         out_turns
);

    logic [4:0]                    valid_reg;
    logic                          neg_reg [0:3];
    logic [gcb_pkg::DEG_W-1:0]     mag1_reg, mag2_reg;
    logic [gcb_pkg::QUO_W-1:0]     quo2_reg, quo3_reg, quo4_reg;
    logic [gcb_pkg::REM_W-1:0]     rem3_reg;
    logic [gcb_pkg::FRAC_W-1:0]    frac4_reg;
    logic [gcb_pkg::TURN_W-1:0]    turns_reg;

    logic [gcb_pkg::DEG_W-1:0]     mag_next;
    logic [51:0]                   quo_prod;
    logic [44:0]                   frac_prod;
    logic [33:0]                   whole;
    logic [gcb_pkg::TURN_W-1:0]    turns_next;

    always_comb
    begin
        mag_next   = in_deg[gcb_pkg::DEG_W-1] ? 26'(-in_deg) : 26'(in_deg);
        quo_prod   = 52'(mag1_reg) * 52'(gcb_pkg::RECIP_45);
        frac_prod  = 45'({rem3_reg, 13'b0}) * 45'(gcb_pkg::RECIP_45);
        whole      = 34'({quo4_reg, 13'b0}) + 34'(frac4_reg);
        turns_next = neg_reg[3] ? 32'(-whole) : 32'(whole);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= in_deg[gcb_pkg::DEG_W-1];
            neg_reg[1] <= neg_reg[0];
            neg_reg[2] <= neg_reg[1];
            neg_reg[3] <= neg_reg[2];
            mag1_reg   <= mag_next;
            mag2_reg   <= mag1_reg;
            quo2_reg   <= 20'(quo_prod >> gcb_pkg::RECIP_SH);
            quo3_reg   <= quo2_reg;
            rem3_reg   <= 6'(mag2_reg - 26'(quo2_reg) * 26'd45);
            quo4_reg   <= quo3_reg;
            frac4_reg  <= 13'(frac_prod >> gcb_pkg::RECIP_SH);
            turns_reg  <= turns_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_turns = turns_reg;

endmodule
`default_nettype wire

>>> sv/gcb_sincos.sv
// Pipelined rotation CORDIC: sine and cosine in Q30 of an angle in turns.
`default_nettype none
module gcb_sincos #(
    parameter int STAGES = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic [gcb_pkg::TURN_W-1:0]      ang,
    output logic                                 out_valid,
    output logic signed [gcb_pkg::TURN_W-1:0]    sin_q30,
    output logic signed [gcb_pkg::TURN_W-1:0]    cos_q30
);

    logic signed [gcb_pkg::ROT_W-1:0] x_reg [0:STAGES];
    logic signed [gcb_pkg::ROT_W-1:0] y_reg [0:STAGES];
    logic signed [gcb_pkg::ROT_W-1:0] z_reg [0:STAGES];
    logic                             flip_reg [0:STAGES];
    logic [STAGES:0]                  valid_reg;
    logic                             out_valid_reg;
    logic signed [gcb_pkg::TURN_W-1:0] sin_reg, cos_reg;

    logic signed [gcb_pkg::TURN_W-1:0] z_in, z_alt;
    logic                              wide;

    always_comb
    begin
        z_in  = signed'(ang);
        z_alt = signed'(ang + 32'h8000_0000);
        wide  = (z_in > gcb_pkg::QUARTER_TURN) || (z_in < -gcb_pkg::QUARTER_TURN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[STAGES-1:0], in_valid};
            out_valid_reg <= valid_reg[STAGES];
        end
    end

    // Angles beyond a quarter turn are folded by a half turn and the result negated.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= gcb_pkg::GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= wide ? 34'(z_alt) : 34'(z_in);
            flip_reg[0] <= wide;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][gcb_pkg::ROT_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - 34'(gcb_pkg::atan_turn(5'(i)));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + 34'(gcb_pkg::atan_turn(5'(i)));
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= flip_reg[STAGES] ? 32'(-y_reg[STAGES]) : 32'(y_reg[STAGES]);
            cos_reg <= flip_reg[STAGES] ? 32'(-x_reg[STAGES]) : 32'(x_reg[STAGES]);
        end
    end

    assign out_valid = out_valid_reg;
    assign sin_q30   = sin_reg;
    assign cos_q30   = cos_reg;

endmodule
`default_nettype wire

>>> sv/gcb_atan2.sv
// Pipelined vectoring CORDIC: atan2 of a vector, result in signed turns.
`default_nettype none
module gcb_atan2 #(
    parameter int STAGES = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic                            in_zero,
    input  wire logic signed [gcb_pkg::ROT_W-1:0] vx,
    input  wire logic signed [gcb_pkg::ROT_W-1:0] vy,
    output logic                                 out_valid,
    output logic                                 out_zero,
    output logic signed [gcb_pkg::TURN_W-1:0]    angle
);

    logic signed [gcb_pkg::VEC_W-1:0] x_reg [0:STAGES];
    logic signed [gcb_pkg::VEC_W-1:0] y_reg [0:STAGES];
    logic signed [gcb_pkg::ROT_W-1:0] z_reg [0:STAGES];
    logic                             zero_reg [0:STAGES];
    logic [STAGES:0]                  valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-1:0], in_valid};
        end
    end

    // A vector in the left half plane is turned by a half turn first.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (vx[gcb_pkg::ROT_W-1])
            begin
                x_reg[0] <= -36'(vx);
                y_reg[0] <= -36'(vy);
                z_reg[0] <= 34'sh0_8000_0000;
            end
            else
            begin
                x_reg[0] <= 36'(vx);
                y_reg[0] <= 36'(vy);
                z_reg[0] <= '0;
            end
            zero_reg[0] <= in_zero;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + 34'(gcb_pkg::atan_turn(5'(i)));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - 34'(gcb_pkg::atan_turn(5'(i)));
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_zero  = zero_reg[STAGES];
    assign angle     = signed'(z_reg[STAGES][gcb_pkg::TURN_W-1:0]);

endmodule
`default_nettype wire

>>> sv/great_circle_bearing_top.sv
// Top level of the great-circle initial bearing pipeline.
//
//  port group   direction  payload
//  s_axis       in         observer latitude and longitude
//  m_axis       out        bearing in whole degrees
//  cfg          in         destination latitude and longitude registers
//
// One beat is accepted every cycle while the output is not stalled; most of the latency lies in
// the two CORDIC pipelines in series, one iteration per stage.
// Reset clears all valid bits and loads the default destination.
// When the output beat is not taken, the whole pipeline holds and s_axis_tready drops.
`default_nettype none
module great_circle_bearing_top #(
    parameter int CORDIC_STAGES = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // obs_latitude[23:0], obs_longitude[48:24]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // bearing_deg[8:0]
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [24:0] cfg_data
);

    logic signed [gcb_pkg::LAT_W-1:0] dest_lat_reg;
    logic signed [gcb_pkg::LON_W-1:0] dest_lon_reg;

    logic en;
    logic signed [gcb_pkg::LAT_W-1:0] obs_lat;
    logic signed [gcb_pkg::LON_W-1:0] obs_lon;
    logic signed [gcb_pkg::DEG_W-1:0] lat_a_deg, lat_b_deg, dlon_deg;

    logic                          cv_a, cv_b, cv_d;
    logic [gcb_pkg::TURN_W-1:0]    turn_a, turn_b, turn_d;
    logic                          sv_a, sv_b, sv_d;
    logic signed [gcb_pkg::TURN_W-1:0] sa, ca, sb, cb, sd, cd;

    logic signed [63:0] p_y, p_t1, p_t2, p_t3;
    logic signed [gcb_pkg::ROT_W-1:0]  y1_reg, t1_reg, y2_reg, t12_reg, t3_reg;
    logic signed [gcb_pkg::TURN_W-1:0] t2_reg, cd1_reg;
    logic signed [gcb_pkg::ROT_W-1:0]  x3_reg, y3_reg, x_next;
    logic                              zero3_reg;
    logic [2:0]                        mv_reg;

    logic                              av, azero;
    logic signed [gcb_pkg::TURN_W-1:0] ang;
    logic [32:0]                       amag;
    logic [41:0]                       aprod;
    logic [gcb_pkg::BRG_W-1:0]         whole_deg, deg_next;

    logic                      out_valid_reg;
    logic [gcb_pkg::BRG_W-1:0] out_deg_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en && rst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_lat_reg <= gcb_pkg::DEST_LAT_RST;
            dest_lon_reg <= gcb_pkg::DEST_LON_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gcb_pkg::REG_DEST_LAT: dest_lat_reg <= signed'(cfg_data[23:0]);
                gcb_pkg::REG_DEST_LON: dest_lon_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        obs_lat   = signed'(s_axis_tdata[23:0]);
        obs_lon   = signed'(s_axis_tdata[48:24]);
        lat_a_deg = 26'(obs_lat);
        lat_b_deg = 26'(dest_lat_reg);
        dlon_deg  = 26'(dest_lon_reg) - 26'(obs_lon);
    end

    gcb_deg2turn u_conv_a (.clk, .rst_n, .en, .in_valid(s_axis_tvalid), .in_deg(lat_a_deg),
                           .out_valid(cv_a), .out_turns(turn_a));
    gcb_deg2turn u_conv_b (.clk, .rst_n, .en, .in_valid(s_axis_tvalid), .in_deg(lat_b_deg),
                           .out_valid(cv_b), .out_turns(turn_b));
    gcb_deg2turn u_conv_d (.clk, .rst_n, .en, .in_valid(s_axis_tvalid), .in_deg(dlon_deg),
                           .out_valid(cv_d), .out_turns(turn_d));

    gcb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_a (.clk, .rst_n, .en, .in_valid(cv_a),
        .ang(turn_a), .out_valid(sv_a), .sin_q30(sa), .cos_q30(ca));
    gcb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_b (.clk, .rst_n, .en, .in_valid(cv_b),
        .ang(turn_b), .out_valid(sv_b), .sin_q30(sb), .cos_q30(cb));
    gcb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_d (.clk, .rst_n, .en, .in_valid(cv_d),
        .ang(turn_d), .out_valid(sv_d), .sin_q30(sd), .cos_q30(cd));

    always_comb
    begin
        p_y    = cb * sd;
        p_t1   = ca * sb;
        p_t2   = sa * cb;
        p_t3   = t2_reg * cd1_reg;
        x_next = t12_reg - t3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= '0;
        end
        else if (en)
        begin
            mv_reg <= {mv_reg[1:0], sv_a && sv_b && sv_d};
        end
    end

    // The cos(dLon) product needs the registered sa*cb product, so it lands one stage later.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg    <= 34'(p_y >>> 30);
            t1_reg    <= 34'(p_t1 >>> 30);
            t2_reg    <= 32'(p_t2 >>> 30);
            cd1_reg   <= cd;
            y2_reg    <= y1_reg;
            t12_reg   <= t1_reg;
            t3_reg    <= 34'(p_t3 >>> 30);
            x3_reg    <= x_next;
            y3_reg    <= y2_reg;
            zero3_reg <= (x_next == '0) && (y2_reg == '0);
        end
    end

    gcb_atan2 #(.STAGES(CORDIC_STAGES)) u_atan (.clk, .rst_n, .en, .in_valid(mv_reg[2]),
        .in_zero(zero3_reg), .vx(x3_reg), .vy(y3_reg),
        .out_valid(av), .out_zero(azero), .angle(ang));

    // Degrees truncate toward zero; a negative angle then wraps by a full circle.
    always_comb
    begin
        amag      = ang[gcb_pkg::TURN_W-1] ? 33'(-34'(ang)) : 33'(ang);
        aprod     = 42'(amag) * 42'd360;
        whole_deg = 9'(aprod >> 32);
        if (azero)
        begin
            deg_next = '0;
        end
        else if (ang[gcb_pkg::TURN_W-1] && (whole_deg != '0))
        begin
            deg_next = 9'd360 - whole_deg;
        end
        else
        begin
            deg_next = whole_deg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= av;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_deg_reg <= deg_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 16'(out_deg_reg);

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (out_valid_reg && !m_axis_tready))
        else $error("input stalled while the output stage could move");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_deg_reg < 9'd360))
        else $error("bearing out of range");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (sv_a == sv_b) && (sv_b == sv_d))
        else $error("sine/cosine lanes out of step");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(mv_reg) && $stable(out_deg_reg))
        else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the great-circle bearing pipeline.
`timescale 1ns / 1ps
module tb_top;

    localparam int STAGES    = 20;
    localparam int LATENCY   = 2 * STAGES + 12;
    localparam int IDLE_LIM  = 5000;
    localparam int RAND_ITEMS = 160;

    localparam logic [31:0] ATAN_TBL [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [gcb_pkg::LON_W-1:0] lon;
        logic signed [gcb_pkg::LAT_W-1:0] lat;
    } position_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [24:0] cfg_data;

    great_circle_bearing_top #(.CORDIC_STAGES(STAGES)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    position_t   pending_pos[$];
    logic [8:0]  bearing_q[$];
    position_t   cur_pos;
    longint      dest_lat;
    longint      dest_lon;
    int          fails;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          stall_left;
    int          idle_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] to_turns(input longint dq16);
        longint q;
        q = (dq16 * 65536) / 360;
        return 32'(q);
    endfunction

    task automatic rotate(input logic [31:0] ang, output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        logic   flip;
        logic [31:0] moved;
        z = longint'($signed(ang));
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1073741824 || z < -64'sd1073741824)
        begin
            moved = ang + 32'h80000000;
            z = longint'($signed(moved));
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(ATAN_TBL[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(ATAN_TBL[i]);
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic longint vector_angle(input longint yi, input longint xi);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic [63:0] zu;
        x = xi; y = yi; z = 0;
        if (x < 0)
        begin
            x = -x; y = -y; z = 64'sd2147483648;
        end
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(ATAN_TBL[i]);
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(ATAN_TBL[i]);
            end
        end
        zu = z;
        return longint'($signed(zu[31:0]));
    endfunction

    task automatic predict_bearing(input position_t p, output logic [8:0] brg);
        longint sa, ca, sb, cb, sd, cd, x, y, a, d;
        longint lat_a, lon_a;
        lat_a = longint'(p.lat);
        lon_a = longint'(p.lon);
        rotate(to_turns(lat_a), sa, ca);
        rotate(to_turns(dest_lat), sb, cb);
        rotate(to_turns(dest_lon - lon_a), sd, cd);
        y = (cb * sd) >>> 30;
        x = ((ca * sb) >>> 30) - ((((sa * cb) >>> 30) * cd) >>> 30);
        if (x == 0 && y == 0)
            d = 0;
        else
        begin
            a = vector_angle(y, x);
            d = (a * 360) / 64'sd4294967296;
            if (d < 0)
                d += 360;
        end
        brg = d[8:0];
    endtask

    // Driver: bursts of beats separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        logic [8:0] brg;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_bearing(cur_pos, brg);
                bearing_q.push_back(brg);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_pos.size() > 0)
                begin
                    cur_pos = pending_pos.pop_front();
                    s_axis_tdata <= {7'b0, cur_pos.lon, cur_pos.lat};
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: switches among free-running, random and heavy stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(16, 96);
            end
            stall_left--;
            unique case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: each output beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        logic [8:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (bearing_q.size() == 0)
            begin
                $error("unexpected beat: bearing_deg actual %0d", m_axis_tdata[8:0]);
                fails++;
            end
            else
            begin
                want = bearing_q.pop_front();
                if (m_axis_tdata[8:0] !== want)
                begin
                    $error("bearing_deg mismatch: expected %0d actual %0d",
                           want, m_axis_tdata[8:0]);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (pending_pos.size() == 0 && bearing_q.size() == 0 && !s_axis_tvalid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic add_pos(input longint lat, input longint lon);
        position_t p;
        p.lat = lat[gcb_pkg::LAT_W-1:0];
        p.lon = lon[gcb_pkg::LON_W-1:0];
        pending_pos.push_back(p);
    endtask

    task automatic write_reg(input logic idx, input longint val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[24:0];
        if (idx == gcb_pkg::REG_DEST_LAT)
            dest_lat = longint'($signed(val[gcb_pkg::LAT_W-1:0]));
        else
            dest_lon = longint'($signed(val[gcb_pkg::LON_W-1:0]));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pos.size() > 0 || s_axis_tvalid || bearing_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                add_pos(longint'($signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8),
                        longint'($signed($urandom_range(0, 32'h1FFFFFF) << 7) >>> 7));
            else
                add_pos(longint'($urandom_range(0, 11796480)) - 5898240,
                        longint'($urandom_range(0, 23592960)) - 11796480);
        end
    endtask

    initial
    begin
        fails = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = gcb_pkg::REG_DEST_LAT;
        cfg_data = '0;
        dest_lat = 1403947;
        dest_lon = 2610049;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes, poles, out-of-range bit patterns and the default destination.
        add_pos(0, 0);
        add_pos(5898240, 11796480);
        add_pos(-5898240, -11796480);
        add_pos(5898240, 0);
        add_pos(-5898240, 0);
        add_pos(0, 11796480);
        add_pos(0, -11796480);
        add_pos(8388607, 16777215);
        add_pos(-8388608, -16777216);
        add_pos(-1, -1);
        add_pos(1403947, 2610049);
        add_pos(-1403947, 2610049 - 11796480);
        // Same meridian: due north and due south of the destination.
        add_pos(0, 2610049);
        add_pos(3000000, 2610049);
        add_pos(1403947, 2610049 + 11796480);
        add_pos(1403946, 2610050);
        add_pos(1, 1);
        add_pos(2949120, -5898240);
        drain();
        add_random(RAND_ITEMS);
        drain();

        write_reg(gcb_pkg::REG_DEST_LAT, 5898240);
        write_reg(gcb_pkg::REG_DEST_LON, 11796480);
        add_pos(0, 0);
        add_pos(5898240, 11796480);
        add_random(RAND_ITEMS);
        drain();

        write_reg(gcb_pkg::REG_DEST_LAT, -5898240);
        write_reg(gcb_pkg::REG_DEST_LON, -11796480);
        add_pos(-5898240, -11796480);
        add_pos(5898240, 0);
        add_random(RAND_ITEMS);
        drain();

        write_reg(gcb_pkg::REG_DEST_LAT, 0);
        write_reg(gcb_pkg::REG_DEST_LON, 0);
        add_pos(0, 0);
        add_pos(0, 11796480);
        add_random(RAND_ITEMS);
        drain();

        write_reg(gcb_pkg::REG_DEST_LAT, longint'($urandom_range(0, 11796480)) - 5898240);
        write_reg(gcb_pkg::REG_DEST_LON, longint'($urandom_range(0, 23592960)) - 11796480);
        add_random(RAND_ITEMS);
        drain();

        write_reg(gcb_pkg::REG_DEST_LAT, longint'($urandom_range(0, 32'hFFFFFF)));
        write_reg(gcb_pkg::REG_DEST_LON, longint'($urandom_range(0, 32'h1FFFFFF)));
        add_random(RAND_ITEMS);
        drain();

        if (fails == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
